>>> rtl/core/skvt_pkg.sv
package skvt_pkg;

   // Table depth; the field widths below are sized for it.
   localparam int CAPACITY = 64;

   typedef enum logic [3:0] {
      FUNC_GET            = 4'd0,
      FUNC_PUT            = 4'd1,
      FUNC_DELETE         = 4'd2,
      FUNC_REMOVE_AT      = 4'd3,
      FUNC_KEY_AT         = 4'd4,
      FUNC_VALUE_AT       = 4'd5,
      FUNC_INDEX_OF_KEY   = 4'd6,
      FUNC_INDEX_OF_VALUE = 4'd7,
      FUNC_CLEAR          = 4'd8,
      FUNC_APPEND         = 4'd9,
      FUNC_SIZE           = 4'd10
   } func_type;

   localparam logic [1:0] STATUS_OK    = 2'd0;
   localparam logic [1:0] STATUS_FULL  = 2'd1;
   localparam logic [1:0] STATUS_RANGE = 2'd2;

   typedef struct packed {
      logic [3:0]         func;
      logic signed [31:0] key_in;
      logic signed [31:0] value_in;
      logic [5:0]         position_in;
   } req_type;

   typedef struct packed {
      logic signed [31:0] value_out;
      logic signed [31:0] key_out;
      logic signed [7:0]  position_out;
      logic               found;
      logic [6:0]         entry_count;
      logic [1:0]         status;
   } rsp_type;

endpackage

>>> rtl/core/skvt_if.sv
interface skvt_req_if;
   import skvt_pkg::*;
   logic    valid;
   logic    ready;
   req_type data;
   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

interface skvt_rsp_if;
   import skvt_pkg::*;
   logic    valid;
   logic    ready;
   rsp_type data;
   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

>>> rtl/core/sorted_key_value_table_unit.sv
// Channel  | Direction | Payload
// req      | in        | func, key_in, value_in, position_in
// rsp      | out       | value_out, key_out, position_out, found, entry_count, status
//
// One request is worked at a time. Each binary search step of a key search
// is a memory read, then a compare, in separate states.
// Insert and remove then move the entries one by one (read, then write);
// index_of_value likewise reads and compares the entries one by one.
// Reset clears the count and control only; the stores are never read beyond
// the count. A stalled response holds in its register and blocks new requests.
module sorted_key_value_table_unit (
   input logic clock,
   input logic reset,
   skvt_req_if.sink   req,
   skvt_rsp_if.source rsp
);
   import skvt_pkg::*;

   localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int CW = $clog2(CAPACITY + 1);

   typedef enum logic [8:0] {
      ST_IDLE   = 9'b000000001,
      ST_SREAD  = 9'b000000010,
      ST_SCMP   = 9'b000000100,
      ST_DECIDE = 9'b000001000,
      ST_SHREAD = 9'b000010000,
      ST_SHWR   = 9'b000100000,
      ST_VSCAN  = 9'b001000000,
      ST_VCMP   = 9'b010000000,
      ST_RESP   = 9'b100000000
   } state_type;

   // Two stores, each one write port and one registered read port.
   logic [31:0] key_mem [CAPACITY];
   logic [31:0] val_mem [CAPACITY];
   logic [31:0] key_rd, val_rd;
   logic [AW-1:0] rd_addr, wr_addr;
   logic          wr_en;
   logic [31:0]   wr_key, wr_val;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         key_mem[wr_addr] <= wr_key;
         val_mem[wr_addr] <= wr_val;
      end
      key_rd <= key_mem[rd_addr];
      val_rd <= val_mem[rd_addr];
   end

   state_type   state_ff, state_in;
   req_type     cur_ff, cur_in;
   logic [CW-1:0] count_ff, count_in;
   logic [CW-1:0] lo_ff, lo_in, hi_ff, hi_in, idx_ff, idx_in;
   logic          hit_ff, hit_in;
   logic          ins_ff, ins_in;   // shift direction: 1 insert (downward walk)
   rsp_type       rsp_ff, rsp_in;
   logic          rvalid_ff, rvalid_in;

   logic [CW:0]   mid_w;
   logic [CW-1:0] mid;
   logic          less_mk, less_km;
   logic [31:0]   key_u;
   logic [7:0]    scode;
   logic [CW-1:0] cur_pos;

   assign key_u   = cur_ff.key_in;
   assign mid_w   = ({1'b0, lo_ff} + {1'b0, hi_ff}) >> 1;
   assign mid     = mid_w[CW-1:0];
   assign less_mk = (key_rd ^ 32'h8000_0000) < (key_u ^ 32'h8000_0000);
   assign less_km = (key_u ^ 32'h8000_0000) < (key_rd ^ 32'h8000_0000);
   assign scode   = hit_ff ? 8'(idx_ff) : ~8'(lo_ff);
   assign cur_pos = CW'(cur_ff.position_in);

   assign req.ready  = (state_ff == ST_IDLE) && !rvalid_ff;
   assign rsp.valid  = rvalid_ff;
   assign rsp.data   = rsp_ff;

   always_comb begin
      state_in  = state_ff;
      cur_in    = cur_ff;
      count_in  = count_ff;
      lo_in     = lo_ff;
      hi_in     = hi_ff;
      idx_in    = idx_ff;
      hit_in    = hit_ff;
      ins_in    = ins_ff;
      rsp_in    = rsp_ff;
      rvalid_in = rvalid_ff;
      rd_addr   = mid[AW-1:0];
      wr_en     = 1'b0;
      wr_addr   = idx_ff[AW-1:0];
      wr_key    = key_rd;
      wr_val    = val_rd;

      if (rvalid_ff && rsp.ready) begin
         rvalid_in = 1'b0;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req.valid && !rvalid_ff) begin
               cur_in = req.data;
               lo_in  = '0;
               hi_in  = count_ff;
               hit_in = 1'b0;
               idx_in = '0;
               rsp_in = '0;
               state_in = ST_DECIDE;
               unique case (req.data.func)
                  FUNC_GET, FUNC_PUT, FUNC_DELETE, FUNC_INDEX_OF_KEY:
                     state_in = ST_SREAD;
                  FUNC_APPEND: begin
                     // Read the last key first to check for a plain append.
                     state_in = ST_SCMP;
                     ins_in   = 1'b1;
                     rd_addr  = AW'(count_ff - CW'(1));
                     if (count_ff == '0) begin
                        state_in = ST_DECIDE;
                     end
                  end
                  FUNC_REMOVE_AT, FUNC_KEY_AT, FUNC_VALUE_AT: begin
                     rd_addr  = req.data.position_in[AW-1:0];
                     idx_in   = CW'(req.data.position_in);
                  end
                  FUNC_INDEX_OF_VALUE: state_in = ST_VSCAN;
                  default: ;
               endcase
            end
         end
         ST_SREAD: begin
            ins_in = 1'b0;
            if (lo_ff < hi_ff) begin
               state_in = ST_SCMP;   // read at mid issued this cycle
            end else begin
               state_in = ST_DECIDE;
            end
         end
         ST_SCMP: begin
            if (ins_ff) begin
               // Append check against last key.
               ins_in = 1'b0;
               if (less_mk) begin
                  lo_in    = count_ff;
                  state_in = ST_DECIDE;
               end else begin
                  state_in = ST_SREAD;
               end
            end else if (less_mk) begin
               lo_in    = mid + CW'(1);
               state_in = ST_SREAD;
            end else if (less_km) begin
               hi_in    = mid;
               state_in = ST_SREAD;
            end else begin
               hit_in   = 1'b1;
               idx_in   = mid;
               state_in = ST_DECIDE;
            end
         end
         ST_DECIDE: begin
            state_in = ST_RESP;
            unique case (cur_ff.func)
               FUNC_GET: begin
                  rsp_in.value_out    = hit_ff ? val_rd : cur_ff.value_in;
                  rsp_in.position_out = scode;
                  rsp_in.found        = hit_ff;
               end
               FUNC_INDEX_OF_KEY: begin
                  rsp_in.position_out = scode;
                  rsp_in.found        = hit_ff;
               end
               FUNC_PUT, FUNC_APPEND: begin
                  rsp_in.position_out = scode;
                  rsp_in.found        = hit_ff;
                  if (hit_ff) begin
                     wr_en   = 1'b1;
                     wr_addr = idx_ff[AW-1:0];
                     wr_key  = key_u;
                     wr_val  = cur_ff.value_in;
                  end else if (count_ff >= CW'(CAPACITY)) begin
                     rsp_in.status = STATUS_FULL;
                  end else begin
                     // Shift up from the top down to the insertion point.
                     ins_in = 1'b1;
                     idx_in = count_ff;
                     lo_in  = lo_ff;
                     state_in = ST_SHREAD;
                  end
               end
               FUNC_DELETE: begin
                  rsp_in.position_out = scode;
                  rsp_in.found        = hit_ff;
                  if (hit_ff) begin
                     ins_in   = 1'b0;
                     state_in = ST_SHREAD;
                  end
               end
               FUNC_REMOVE_AT, FUNC_KEY_AT, FUNC_VALUE_AT: begin
                  if (cur_pos >= count_ff) begin
                     rsp_in.status = STATUS_RANGE;
                  end else begin
                     rsp_in.position_out = 8'(cur_ff.position_in);
                     if (cur_ff.func == FUNC_KEY_AT) rsp_in.key_out = key_rd;
                     if (cur_ff.func == FUNC_VALUE_AT) rsp_in.value_out = val_rd;
                     if (cur_ff.func == FUNC_REMOVE_AT) begin
                        ins_in   = 1'b0;
                        state_in = ST_SHREAD;
                     end
                  end
               end
               FUNC_CLEAR: count_in = '0;
               default: ;
            endcase
            rsp_in.entry_count = 7'(count_in);
         end
         ST_SHREAD: begin
            // Insert: idx walks from count down to pos, copying idx-1 to idx.
            // Remove: idx walks up from pos, copying idx+1 to idx.
            if (ins_ff) begin
               if (idx_ff == lo_ff) begin
                  wr_en    = 1'b1;
                  wr_addr  = idx_ff[AW-1:0];
                  wr_key   = key_u;
                  wr_val   = cur_ff.value_in;
                  count_in = count_ff + CW'(1);
                  state_in = ST_RESP;
               end else begin
                  rd_addr  = AW'(idx_ff - CW'(1));
                  state_in = ST_SHWR;
               end
            end else begin
               if (idx_ff + CW'(1) >= count_ff) begin
                  count_in = count_ff - CW'(1);
                  state_in = ST_RESP;
               end else begin
                  rd_addr  = AW'(idx_ff + CW'(1));
                  state_in = ST_SHWR;
               end
            end
            rsp_in.entry_count = 7'(count_in);
         end
         ST_SHWR: begin
            wr_en   = 1'b1;
            wr_addr = idx_ff[AW-1:0];
            idx_in  = ins_ff ? idx_ff - CW'(1) : idx_ff + CW'(1);
            state_in = ST_SHREAD;
         end
         ST_VSCAN: begin
            if (idx_ff >= count_ff) begin
               rsp_in.position_out = 8'hFF;
               rsp_in.entry_count  = 7'(count_ff);
               state_in = ST_RESP;
            end else begin
               rd_addr  = idx_ff[AW-1:0];
               state_in = ST_VCMP;
            end
         end
         ST_VCMP: begin
            if (val_rd == cur_ff.value_in) begin
               rsp_in.position_out = 8'(idx_ff);
               rsp_in.found        = 1'b1;
               rsp_in.entry_count  = 7'(count_ff);
               state_in = ST_RESP;
            end else begin
               idx_in   = idx_ff + CW'(1);
               state_in = ST_VSCAN;
            end
         end
         ST_RESP: begin
            rvalid_in = 1'b1;
            state_in  = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         count_ff  <= '0;
         rvalid_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         count_ff  <= count_in;
         rvalid_ff <= rvalid_in;
      end
      cur_ff <= cur_in;
      lo_ff  <= lo_in;
      hi_ff  <= hi_in;
      idx_ff <= idx_in;
      hit_ff <= hit_in;
      ins_ff <= ins_in;
      rsp_ff <= rsp_in;
   end

   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(CAPACITY)) else $error("count beyond capacity");
   a_no_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (req.valid && req.ready) |=> state_ff != ST_IDLE)
      else $error("accepted request left no work");
   a_count_step: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE) |=> (count_ff == $past(count_ff)))
      else $error("count changed while idle");
   a_resp_hold: assert property (@(posedge clock) disable iff (reset)
      (rvalid_ff && !rsp.ready) |=> rvalid_ff && state_ff == ST_IDLE)
      else $error("stalled response lost");

endmodule

>>> bench/tb_sorted_key_value_table_unit.sv
module tb_sorted_key_value_table_unit;
   import skvt_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int TABLE_DEPTH = CAPACITY;

   // The scoreboard keeps its own copy of the sorted table and predicts each
   // response from the requests as they are accepted, in the order accepted.
   class table_scoreboard;
      logic [31:0] keys [TABLE_DEPTH];
      logic [31:0] vals [TABLE_DEPTH];
      int          n_entries;
      rsp_type     pending [$];
      int          mismatches;
      int          checked;

      function void wipe();
         n_entries = 0;
         pending.delete();
         mismatches = 0;
         checked = 0;
      endfunction

      // Binary search on signed keys; returns hit, pos is index or insertion point.
      function bit lookup(logic signed [31:0] k, output int pos);
         int lo;
         int hi;
         int mid;
         lo = 0;
         hi = n_entries;
         while (lo < hi) begin
            mid = (lo + hi) / 2;
            if ($signed(keys[mid]) < k) begin
               lo = mid + 1;
            end else if (k < $signed(keys[mid])) begin
               hi = mid;
            end else begin
               pos = mid;
               return 1'b1;
            end
         end
         pos = lo;
         return 1'b0;
      endfunction

      function logic [7:0] code(bit hit, int pos);
         return hit ? 8'(pos) : ~8'(pos);
      endfunction

      function void drop_at(int pos);
         for (int i = pos; i < n_entries - 1; i++) begin
            keys[i] = keys[i + 1];
            vals[i] = vals[i + 1];
         end
         n_entries--;
      endfunction

      function logic [1:0] store(logic [31:0] k, logic [31:0] v, bit hit, int pos);
         if (hit) begin
            vals[pos] = v;
            return STATUS_OK;
         end
         if (n_entries >= TABLE_DEPTH) return STATUS_FULL;
         for (int i = n_entries; i > pos; i--) begin
            keys[i] = keys[i - 1];
            vals[i] = vals[i - 1];
         end
         keys[pos] = k;
         vals[pos] = v;
         n_entries++;
         return STATUS_OK;
      endfunction

      function void note_request(req_type r);
         rsp_type e;
         int      pos;
         bit      hit;
         e = '0;
         pos = 0;
         case (r.func)
            FUNC_GET: begin
               hit = lookup(r.key_in, pos);
               e.value_out = hit ? vals[pos] : r.value_in;
               e.position_out = code(hit, pos);
               e.found = hit;
            end
            FUNC_PUT: begin
               hit = lookup(r.key_in, pos);
               e.position_out = code(hit, pos);
               e.found = hit;
               e.status = store(r.key_in, r.value_in, hit, pos);
            end
            FUNC_DELETE: begin
               hit = lookup(r.key_in, pos);
               e.position_out = code(hit, pos);
               e.found = hit;
               if (hit) drop_at(pos);
            end
            FUNC_REMOVE_AT, FUNC_KEY_AT, FUNC_VALUE_AT: begin
               if (int'(r.position_in) >= n_entries) begin
                  e.status = STATUS_RANGE;
               end else begin
                  e.position_out = 8'(r.position_in);
                  if (r.func == FUNC_REMOVE_AT) drop_at(r.position_in);
                  else if (r.func == FUNC_KEY_AT) e.key_out = keys[r.position_in];
                  else e.value_out = vals[r.position_in];
               end
            end
            FUNC_INDEX_OF_KEY: begin
               hit = lookup(r.key_in, pos);
               e.position_out = code(hit, pos);
               e.found = hit;
            end
            FUNC_INDEX_OF_VALUE: begin
               e.position_out = -8'sd1;
               for (int i = 0; i < n_entries; i++) begin
                  if (vals[i] == r.value_in) begin
                     e.position_out = 8'(i);
                     e.found = 1'b1;
                     break;
                  end
               end
            end
            FUNC_CLEAR: n_entries = 0;
            FUNC_APPEND: begin
               if (n_entries != 0 && !($signed(keys[n_entries - 1]) < r.key_in)) begin
                  hit = lookup(r.key_in, pos);
                  e.position_out = code(hit, pos);
                  e.found = hit;
                  e.status = store(r.key_in, r.value_in, hit, pos);
               end else begin
                  e.position_out = code(1'b0, n_entries);
                  e.status = store(r.key_in, r.value_in, 1'b0, n_entries);
               end
            end
            default: ;
         endcase
         e.entry_count = 7'(n_entries);
         pending.push_back(e);
      endfunction

      function void check_response(rsp_type got);
         rsp_type e;
         checked++;
         if (pending.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("Unexpected response %p", got);
            return;
         end
         e = pending.pop_front();
         if (got !== e) begin
            mismatches++;
            if (mismatches <= 10) begin
               $display("Mismatch on response %0d:", checked);
               $display("   expected %p", e);
               $display("   actual   %p", got);
            end
         end
      endfunction
   endclass

   logic clock;
   logic reset;

   skvt_req_if req_ch ();
   skvt_rsp_if rsp_ch ();

   sorted_key_value_table_unit dut (
      .clock(clock),
      .reset(reset),
      .req  (req_ch.sink),
      .rsp  (rsp_ch.source)
   );

   table_scoreboard board;

   // Idle probability in percent for each side; zero during the steady stretch.
   int  send_idle_pct;
   int  recv_idle_pct;
   bit  driving_done;
   int  sent_count;
   int  func_seen [16];

   initial clock = 1'b0;
   always #5 clock = ~clock;

   // Response side: randomly stalls ready, and checks each accepted response
   // against the oldest prediction.
   always @(posedge clock) begin
      if (reset) begin
         rsp_ch.ready <= 1'b0;
      end else begin
         if (rsp_ch.valid && rsp_ch.ready) board.check_response(rsp_ch.data);
         rsp_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   // Drives one request, holding valid until it is accepted. Random idle
   // cycles are inserted in front of it. The prediction is taken at the
   // accepting edge so that it follows the accepted order. Valid stays high
   // afterwards; the next request replaces it or wait_drained takes it down.
   task automatic send_request(req_type r);
      while ($urandom_range(99) < send_idle_pct) begin
         req_ch.valid <= 1'b0;
         req_ch.data  <= req_type'($urandom());
         @(posedge clock);
      end
      req_ch.valid <= 1'b1;
      req_ch.data  <= r;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      board.note_request(r);
      func_seen[r.func]++;
      sent_count++;
   endtask

   function automatic req_type make_request(logic [3:0] f, logic [31:0] k,
                                            logic [31:0] v, logic [5:0] p);
      req_type r;
      r.func = f;
      r.key_in = k;
      r.value_in = v;
      r.position_in = p;
      return r;
   endfunction

   // Keys come mostly from a small pool so that lookups hit often, with
   // occasional full-range keys and the extremes.
   function automatic logic [31:0] pick_key();
      int sel;
      sel = $urandom_range(99);
      if (sel < 70) return 32'($urandom_range(40)) - 32'd20;
      if (sel < 75) return 32'h8000_0000;
      if (sel < 80) return 32'h7FFF_FFFF;
      return $urandom();
   endfunction

   function automatic logic [31:0] pick_value();
      if ($urandom_range(1)) return 32'($urandom_range(15));
      return $urandom();
   endfunction

   // Picks a position near the current count so both in-range and
   // out-of-range accesses happen.
   function automatic logic [5:0] pick_position();
      int n;
      n = board.n_entries;
      if ($urandom_range(9) == 0) return 6'($urandom());
      return 6'($urandom_range(n < 63 ? n : 63));
   endfunction

   task automatic wait_drained();
      req_ch.valid <= 1'b0;
      while (board.pending.size() != 0) @(posedge clock);
   endtask

   initial begin
      req_type r;
      int      sel;
      logic [3:0] f;
      reset         = 1'b1;
      req_ch.valid  = 1'b0;
      req_ch.data   = '0;
      send_idle_pct = 33;
      recv_idle_pct = 33;
      driving_done  = 1'b0;
      sent_count    = 0;
      board = new();
      board.wipe();
      foreach (func_seen[i]) func_seen[i] = 0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed part: empty-table cases, the key extremes, every operation,
      // append below the last key, delete of an absent key, unused codes.
      send_request(make_request(FUNC_SIZE, '0, '0, '0));
      send_request(make_request(FUNC_GET, 32'd5, 32'hDEAD_BEEF, '0));
      send_request(make_request(FUNC_KEY_AT, '0, '0, 6'd0));
      send_request(make_request(FUNC_INDEX_OF_VALUE, '0, 32'd1, '0));
      send_request(make_request(FUNC_APPEND, 32'd10, 32'd100, '0));
      send_request(make_request(FUNC_PUT, 32'h8000_0000, 32'hFFFF_FFFF, '0));
      send_request(make_request(FUNC_PUT, 32'h7FFF_FFFF, 32'h8000_0000, '0));
      send_request(make_request(FUNC_APPEND, 32'd3, 32'd33, '0));
      send_request(make_request(FUNC_PUT, 32'd10, 32'h7FFF_FFFF, '0));
      send_request(make_request(FUNC_GET, 32'd10, '0, '0));
      send_request(make_request(FUNC_GET, 32'd11, 32'h5555_AAAA, '0));
      send_request(make_request(FUNC_INDEX_OF_KEY, 32'd4, '0, '0));
      send_request(make_request(FUNC_INDEX_OF_KEY, 32'h7FFF_FFFF, '0, '0));
      send_request(make_request(FUNC_INDEX_OF_VALUE, '0, 32'h8000_0000, '0));
      send_request(make_request(FUNC_KEY_AT, '0, '0, 6'd0));
      send_request(make_request(FUNC_VALUE_AT, '0, '0, 6'd3));
      send_request(make_request(FUNC_VALUE_AT, '0, '0, 6'd63));
      send_request(make_request(FUNC_DELETE, 32'd77, '0, '0));
      send_request(make_request(FUNC_DELETE, 32'd3, '0, '0));
      send_request(make_request(FUNC_REMOVE_AT, '0, '0, 6'd1));
      send_request(make_request(FUNC_REMOVE_AT, '0, '0, 6'd40));
      send_request(make_request(4'd11, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 6'd63));
      send_request(make_request(4'd15, '0, '0, '0));
      send_request(make_request(FUNC_CLEAR, '0, '0, '0));
      send_request(make_request(FUNC_SIZE, '0, '0, '0));

      // Fill the table past its capacity with ascending appends so that the
      // full-table drop is hit for both append and put.
      for (int i = 0; i < 66; i++) begin
         send_request(make_request(FUNC_APPEND, 32'(i * 3 - 90), $urandom(), '0));
      end
      send_request(make_request(FUNC_PUT, 32'd1, 32'd1, '0));
      send_request(make_request(FUNC_PUT, 32'h8000_0000, 32'd1, '0));
      send_request(make_request(FUNC_PUT, 32'd0, 32'd2, '0));
      send_request(make_request(FUNC_KEY_AT, '0, '0, 6'd63));
      send_request(make_request(FUNC_REMOVE_AT, '0, '0, 6'd63));
      send_request(make_request(FUNC_REMOVE_AT, '0, '0, 6'd0));

      // The sender holds off until every predicted response has arrived.
      wait_drained();

      // Random part. A middle stretch runs with no idling on either side.
      for (int n = 0; n < 350; n++) begin
         if (n == 150) begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
         end else if (n == 250) begin
            send_idle_pct = 33;
            recv_idle_pct = 33;
         end
         sel = $urandom_range(99);
         if (sel < 30) f = FUNC_PUT;
         else if (sel < 40) f = FUNC_APPEND;
         else if (sel < 47) f = FUNC_DELETE;
         else if (sel < 52) f = FUNC_REMOVE_AT;
         else if (sel < 60) f = FUNC_GET;
         else if (sel < 66) f = FUNC_KEY_AT;
         else if (sel < 72) f = FUNC_VALUE_AT;
         else if (sel < 79) f = FUNC_INDEX_OF_KEY;
         else if (sel < 86) f = FUNC_INDEX_OF_VALUE;
         else if (sel < 88) f = FUNC_CLEAR;
         else if (sel < 94) f = FUNC_SIZE;
         else f = 4'($urandom_range(15));
         r = make_request(f, pick_key(), pick_value(), pick_position());
         send_request(r);
      end
      driving_done = 1'b1;

      wait_drained();
      repeat (200) @(posedge clock);

      $display("Sent %0d requests (%0d put, %0d append, %0d delete, %0d remove_at).",
               sent_count, func_seen[FUNC_PUT], func_seen[FUNC_APPEND],
               func_seen[FUNC_DELETE], func_seen[FUNC_REMOVE_AT]);
      $display("Checked %0d responses, %0d mismatches.", board.checked, board.mismatches);
      if (board.mismatches == 0 && board.pending.size() == 0) begin
         $display("*** PASSED ***");
      end else begin
         if (board.pending.size() != 0)
            $display("%0d responses never arrived.", board.pending.size());
         $display("*** FAILED ***");
      end
      $finish;
   end

   // Watchdog: far beyond the slowest correct run of 447 requests with stalls
   // on both sides.
   initial begin
      #5ms;
      $display("Timeout with %0d responses outstanding.", board.pending.size());
      $display("*** FAILED ***");
      $finish;
   end

endmodule
